>>> rtl/core/tsct_pkg.sv
// Shared constants, codes and lookup functions for the Taylor sine/cosine/tangent unit.
package tsct_pkg;

   localparam int FRAC_BITS = 24;
   localparam int WORK_BITS = 30;
   localparam int GUARD_BITS = 30;
   localparam int MAX_TERMS = 12;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] PI_W = signed'(PI_Q60 >> (60 - FRAC_BITS - GUARD_BITS));
   localparam logic signed [63:0] TWO_PI_W = PI_W <<< 1;

   localparam logic [1:0] FUNC_SIN = 2'd0;
   localparam logic [1:0] FUNC_COS = 2'd1;
   localparam logic [1:0] FUNC_TAN = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam logic [3:0] TERMS_RESET = 4'd10;

   function automatic logic [29:0] recip_step(input logic [4:0] k);
      logic [29:0] r;
      case (k)
         5'd1:  r = 30'd536870912;
         5'd2:  r = 30'd178956971;
         5'd3:  r = 30'd89478485;
         5'd4:  r = 30'd53687091;
         5'd5:  r = 30'd35791394;
         5'd6:  r = 30'd25565282;
         5'd7:  r = 30'd19173961;
         5'd8:  r = 30'd14913081;
         5'd9:  r = 30'd11930465;
         5'd10: r = 30'd9761289;
         5'd11: r = 30'd8134408;
         5'd12: r = 30'd6882960;
         5'd13: r = 30'd5899680;
         5'd14: r = 30'd5113056;
         5'd15: r = 30'd4473924;
         5'd16: r = 30'd3947580;
         5'd17: r = 30'd3508960;
         5'd18: r = 30'd3139596;
         5'd19: r = 30'd2825636;
         5'd20: r = 30'd2556528;
         5'd21: r = 30'd2324117;
         5'd22: r = 30'd2122019;
         5'd23: r = 30'd1945184;
         5'd24: r = 30'd1789570;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   function automatic logic [34:0] mag35(input logic signed [35:0] v);
      logic signed [35:0] a;
      a = v[35] ? -v : v;
      return a[34:0];
   endfunction

endpackage

>>> rtl/core/taylor_sin_cos_tan_unit_top.sv
// Taylor series sine, cosine and tangent unit with a shared sequenced multiplier and divider.
//
// Requests arrive on req_valid/req_stall with req_func (0 sine, 1 cosine,
// 2 tangent, 3 gives zero) and req_angle, signed Q8.24 radians. Results
// leave on rsp_valid/rsp_stall as rsp_result_value (Q8.24) and rsp_status
// (1 when the tangent's cosine is zero). csr_valid/csr_ready writes the
// series term count; csr_ready is always high.
// One request at a time: the angle reduction removes one multiple of 2pi
// per step until the angle is in range, then the square of the angle and
// each series term are formed on the shared 34x17 multiplier, which runs
// two passes and a rounding step per product. Sine or cosine run one
// series; tangent runs both series, then a bit-serial division.
// Reset clears the sequencer, drops any pending result and sets the term
// count to 10. A finished result waits in the output register while the
// receiver stalls; the next request is taken meanwhile, and its result is
// held until the output register is free.
module taylor_sin_cos_tan_unit_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic signed [31:0]       req_angle,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_result_value,
   output logic                     rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [3:0]               csr_series_terms
);
   import tsct_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_REDUCE, S_MLO, S_MHI, S_MRND, S_TERM, S_SEND,
      S_DCHK, S_DIV, S_DFIN, S_DONE
   } state_type;

   typedef enum logic [1:0] {RET_X2, RET_TR, RET_TX} mret_type;

   state_type state_ff, state_in;
   mret_type mret_ff, mret_in;
   logic [3:0] terms_ff, terms_in;
   logic [1:0] func_ff, func_in;
   logic [3:0] nterms_ff, nterms_in;
   logic signed [63:0] w_ff, w_in;
   logic signed [35:0] x_ff, x_in, x2_ff, x2_in;
   logic signed [35:0] term_ff, term_in, sum_ff, sum_in, sin_ff, sin_in;
   logic [3:0] n_ff, n_in;
   logic cos_ff, cos_in;
   logic [33:0] ma_ff, ma_in, mb_ff, mb_in;
   logic mneg_ff, mneg_in;
   logic [50:0] pp_ff, pp_in, acc_ff, acc_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] dlow_ff, dlow_in, q_ff, q_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [34:0] uc_ff, uc_in;
   logic dneg_ff, dneg_in;
   logic [31:0] res_ff, res_in;
   logic stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_res_ff, rsp_res_in;
   logic rsp_stat_ff, rsp_stat_in;

   logic [16:0] mb_part;
   logic [67:0] mfull;
   logic [67:0] mrnd;
   logic signed [35:0] mres;
   logic signed [63:0] rshift;
   logic [4:0] kstep;
   logic [36:0] trial;
   logic [34:0] us_v, uc_v;
   logic signed [35:0] out_v;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value = signed'(rsp_res_ff);
   assign rsp_status = rsp_stat_ff;

   always_comb begin
      mb_part = (state_ff == S_MLO) ? mb_ff[16:0] : mb_ff[33:17];
      mfull = {17'd0, acc_ff} + ({17'd0, pp_ff} << 17);
      mrnd = mfull + (68'd1 << (WORK_BITS - 1));
      mres = mneg_ff ? -signed'({2'b00, mrnd[63:30]}) : signed'({2'b00, mrnd[63:30]});
      rshift = (w_ff - PI_W + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      kstep = cos_ff ? {n_ff, 1'b1} : 5'({n_ff, 1'b0} + 5'd2);
      trial = {1'b0, rem_ff[34:0], dlow_ff[31]} - {2'b00, uc_ff};
      us_v = mag35(sin_ff);
      uc_v = mag35(sum_ff);
      out_v = (sum_ff + 36'sd32) >>> (WORK_BITS - FRAC_BITS);
   end

   always_comb begin
      state_in = state_ff;
      mret_in = mret_ff;
      terms_in = terms_ff;
      func_in = func_ff;
      nterms_in = nterms_ff;
      w_in = w_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      term_in = term_ff;
      sum_in = sum_ff;
      sin_in = sin_ff;
      n_in = n_ff;
      cos_in = cos_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      mneg_in = mneg_ff;
      pp_in = pp_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      dlow_in = dlow_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      uc_in = uc_ff;
      dneg_in = dneg_ff;
      res_in = res_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_res_in = rsp_res_ff;
      rsp_stat_in = rsp_stat_ff;

      if (csr_valid) begin
         terms_in = csr_series_terms;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               if (terms_ff == 4'd0) begin
                  nterms_in = 4'd1;
               end else if (terms_ff > 4'(MAX_TERMS)) begin
                  nterms_in = 4'(MAX_TERMS);
               end else begin
                  nterms_in = terms_ff;
               end
               w_in = (64'(req_angle) <<< GUARD_BITS) + PI_W;
               if (req_func == FUNC_NONE) begin
                  res_in = 32'd0;
                  stat_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (w_ff < 0) begin
               w_in = w_ff + TWO_PI_W;
            end else if (w_ff >= TWO_PI_W) begin
               w_in = w_ff - TWO_PI_W;
            end else begin
               x_in = rshift[35:0];
               ma_in = 34'(mag35(rshift[35:0]));
               mb_in = 34'(mag35(rshift[35:0]));
               mneg_in = 1'b0;
               mret_in = RET_X2;
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            pp_in = 51'(ma_ff * mb_part);
            state_in = S_MHI;
         end
         S_MHI: begin
            acc_in = pp_ff;
            pp_in = 51'(ma_ff * mb_part);
            state_in = S_MRND;
         end
         S_MRND: begin
            case (mret_ff)
               RET_X2: begin
                  x2_in = mres;
                  cos_in = (func_ff == FUNC_COS);
                  term_in = (func_ff == FUNC_COS) ? (36'sd1 <<< WORK_BITS) : x_ff;
                  sum_in = 36'sd0;
                  n_in = 4'd0;
                  state_in = S_TERM;
               end
               RET_TR: begin
                  ma_in = 34'(mag35(mres));
                  mb_in = 34'(mag35(x2_ff));
                  mneg_in = mres[35] ^ x2_ff[35];
                  mret_in = RET_TX;
                  state_in = S_MLO;
               end
               RET_TX: begin
                  term_in = -mres;
                  n_in = n_ff + 4'd1;
                  state_in = S_TERM;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TERM: begin
            sum_in = sum_ff + term_ff;
            if (n_ff == nterms_ff - 4'd1) begin
               state_in = S_SEND;
            end else begin
               ma_in = 34'(mag35(term_ff));
               mb_in = {4'd0, recip_step(kstep)};
               mneg_in = term_ff[35];
               mret_in = RET_TR;
               state_in = S_MLO;
            end
         end
         S_SEND: begin
            if (func_ff != FUNC_TAN) begin
               res_in = 32'(out_v);
               stat_in = 1'b0;
               state_in = S_DONE;
            end else if (!cos_ff) begin
               sin_in = sum_ff;
               cos_in = 1'b1;
               term_in = 36'sd1 <<< WORK_BITS;
               sum_in = 36'sd0;
               n_in = 4'd0;
               state_in = S_TERM;
            end else begin
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            dneg_in = sin_ff[35] ^ sum_ff[35];
            uc_in = uc_v;
            if (sum_ff == 36'sd0) begin
               res_in = 32'd0;
               stat_in = 1'b1;
               state_in = S_DONE;
            end else if ({8'd0, us_v} >= {uc_v, 8'd0}) begin
               res_in = (sin_ff[35] ^ sum_ff[35]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               stat_in = 1'b0;
               state_in = S_DONE;
            end else begin
               rem_in = {9'd0, us_v[34:8]};
               dlow_in = {us_v[7:0], 24'd0};
               q_in = 32'd0;
               cnt_in = 5'd0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[36]) begin
               rem_in = trial[35:0];
            end else begin
               rem_in = {rem_ff[34:0], dlow_ff[31]};
            end
            q_in = {q_ff[30:0], !trial[36]};
            dlow_in = {dlow_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            stat_in = 1'b0;
            if (dneg_ff) begin
               res_in = (q_ff > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_ff);
            end else begin
               res_in = (q_ff > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_res_in = res_ff;
               rsp_stat_in = stat_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         terms_ff <= TERMS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         terms_ff <= terms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mret_ff <= mret_in;
      func_ff <= func_in;
      nterms_ff <= nterms_in;
      w_ff <= w_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      term_ff <= term_in;
      sum_ff <= sum_in;
      sin_ff <= sin_in;
      n_ff <= n_in;
      cos_ff <= cos_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      mneg_ff <= mneg_in;
      pp_ff <= pp_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dlow_ff <= dlow_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      uc_ff <= uc_in;
      dneg_ff <= dneg_in;
      res_ff <= res_in;
      stat_ff <= stat_in;
      rsp_res_ff <= rsp_res_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule
